@@ rtl/core/stms_pkg.sv @@
// Package: constants, types and control store of the trimmed-mean scaler.
`default_nettype none
package stms_pkg;

	localparam int WINDOW    = 10;
	localparam int TRIM_D    = WINDOW - 2;
	localparam int SAMPLE_W  = 12;
	localparam int SLOT_W    = $clog2(WINDOW);
	localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
	localparam int NUM_W     = SUM_W + 8;
	localparam int QUO_W     = 9;
	localparam int READING_W = 8;
	localparam int TSUM_W    = 15;
	localparam int MODE_W    = 2;
	localparam int PC_W      = 3;
	localparam int RECIP_W   = NUM_W + 2;
	localparam int PROD_W    = NUM_W + RECIP_W;
	localparam int SH_W      = $clog2(PROD_W);

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_REF3V   = 2'd0,
		MODE_SAT3300 = 2'd1,
		MODE_DIV16   = 2'd2,
		MODE_DIV4096 = 2'd3
	} mode_t;

	// scale factor and divisor per mode: floor(s * K / DIV)
	localparam logic [7:0] K_REF3V   = 8'd153;
	localparam logic [7:0] K_SAT3300 = 8'd255;
	localparam logic [7:0] K_DIV16   = 8'd1;
	localparam logic [7:0] K_DIV4096 = 8'd25;

	localparam int DIV_REF3V   = TRIM_D * 4095;
	localparam int DIV_SAT3300 = TRIM_D * 3300;
	localparam int DIV_DIV16   = TRIM_D * 16;
	localparam int DIV_DIV4096 = TRIM_D * 1024;

	// floor(x / DIV) = (x * RCP) >> SH for every x below 2**NUM_W
	localparam int SHN_REF3V   = NUM_W + $clog2(DIV_REF3V);
	localparam int SHN_SAT3300 = NUM_W + $clog2(DIV_SAT3300);
	localparam int SHN_DIV16   = NUM_W + $clog2(DIV_DIV16);
	localparam int SHN_DIV4096 = NUM_W + $clog2(DIV_DIV4096);

	function automatic logic [RECIP_W-1:0] recip_of(input int sh, input int div);
		logic [63:0] scaled;
		scaled = (64'd1 << sh) + 64'(div) - 64'd1;
		return RECIP_W'(scaled / 64'(div));
	endfunction

	localparam logic [RECIP_W-1:0] RCP_REF3V   = recip_of(SHN_REF3V, DIV_REF3V);
	localparam logic [RECIP_W-1:0] RCP_SAT3300 = recip_of(SHN_SAT3300, DIV_SAT3300);
	localparam logic [RECIP_W-1:0] RCP_DIV16   = recip_of(SHN_DIV16, DIV_DIV16);
	localparam logic [RECIP_W-1:0] RCP_DIV4096 = recip_of(SHN_DIV4096, DIV_DIV4096);

	localparam logic [SH_W-1:0] SH_REF3V   = SH_W'(SHN_REF3V);
	localparam logic [SH_W-1:0] SH_SAT3300 = SH_W'(SHN_SAT3300);
	localparam logic [SH_W-1:0] SH_DIV16   = SH_W'(SHN_DIV16);
	localparam logic [SH_W-1:0] SH_DIV4096 = SH_W'(SHN_DIV4096);

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_ACC  = 3'd1,
		OP_TRIM = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_OUT  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_IN_XFER  = 3'd1,
		C_IDX_LAST = 3'd2,
		C_OUT_FREE = 3'd4
	} cond_t;

	localparam logic [PC_W-1:0] PC_LOAD = 3'd0;
	localparam logic [PC_W-1:0] PC_ACC  = 3'd1;
	localparam logic [PC_W-1:0] PC_TRIM = 3'd2;
	localparam logic [PC_W-1:0] PC_MUL  = 3'd3;
	localparam logic [PC_W-1:0] PC_DIV  = 3'd4;
	localparam logic [PC_W-1:0] PC_OUT  = 3'd5;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            hold;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic idx_last;
		logic out_free;
	} status_t;

	// control store: jump to target when cond holds, else hold or step on
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		case (pc)
			PC_LOAD: cw = '{op: OP_LOAD, cond: C_IN_XFER,  target: PC_ACC,  hold: 1'b1};
			PC_ACC:  cw = '{op: OP_ACC,  cond: C_IDX_LAST, target: PC_TRIM, hold: 1'b1};
			PC_TRIM: cw = '{op: OP_TRIM, cond: C_ALWAYS,   target: PC_MUL,  hold: 1'b0};
			PC_MUL:  cw = '{op: OP_MUL,  cond: C_ALWAYS,   target: PC_DIV,  hold: 1'b0};
			PC_DIV:  cw = '{op: OP_DIV,  cond: C_ALWAYS,   target: PC_OUT,  hold: 1'b0};
			PC_OUT:  cw = '{op: OP_OUT,  cond: C_OUT_FREE, target: PC_LOAD, hold: 1'b1};
			default: cw = '{op: OP_LOAD, cond: C_ALWAYS,   target: PC_LOAD, hold: 1'b1};
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/stms_sample_if.sv @@
// Interface: sample input channel.
`default_nettype none
interface stms_sample_if import stms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ rtl/core/stms_result_if.sv @@
// Interface: result output channel.
`default_nettype none
interface stms_result_if import stms_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [READING_W-1:0] reading;
	logic [TSUM_W-1:0]    trimmed_sum;

	modport source (output valid, output reading, output trimmed_sum, input ready);
	modport sink (input valid, input reading, input trimmed_sum, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sensor_trimmed_mean_scaler_core.sv @@
// After a sample transfer the single-adder ring scan sums every slot, then one step
// each for trim, scale multiply, reciprocal multiply and output load follows.
// Output load waits for a free output register; no new sample is taken until then.
// A finished result waits in the output register while the next sample is taken.
// Reset: ring, write slot, scale mode and sequencer clear at once; no clearing pass.
`default_nettype none
module sensor_trimmed_mean_scaler_core import stms_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [MODE_W-1:0] cfg_wdata,
	stms_sample_if.sink       sample_ch,
	stms_result_if.source     result_ch
);

	ctrl_t   ctrl;
	status_t status;

	stms_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	stms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl),
		.status    (status),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

endmodule
`default_nettype wire

@@ rtl/core/stms_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jumps.
`default_nettype none
module stms_seq import stms_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic            cond_ok;

	always_comb begin
		ctrl = ucode(pc_q);
		case (ctrl.cond)
			C_ALWAYS:   cond_ok = 1'b1;
			C_IN_XFER:  cond_ok = status.in_valid;
			C_IDX_LAST: cond_ok = status.idx_last;
			C_OUT_FREE: cond_ok = status.out_free;
			default:    cond_ok = 1'b1;
		endcase
		if (cond_ok) begin
			pc_d = ctrl.target;
		end else if (ctrl.hold) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/stms_dp.sv @@
// Datapath: sample ring, scan accumulator, scale multiply, reciprocal multiply, output register.
`default_nettype none
module stms_dp import stms_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [MODE_W-1:0] cfg_wdata,
	input  ctrl_t             ctrl,
	output status_t           status,
	stms_sample_if.sink       sample_ch,
	stms_result_if.source     result_ch
);

	logic [SAMPLE_W-1:0]  ring_q [WINDOW];
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [SUM_W-1:0]     acc_q;
	logic [SAMPLE_W-1:0]  lo_q;
	logic [SAMPLE_W-1:0]  hi_q;
	logic [SUM_W-1:0]     tsum_q;
	logic [NUM_W-1:0]     num_q;
	logic [PROD_W-1:0]    prod_q;
	mode_t                mode_q;
	logic                 out_valid_q;
	logic [READING_W-1:0] reading_q;
	logic [TSUM_W-1:0]    osum_q;

	logic                 load_xfer;
	logic                 out_load;
	logic [SAMPLE_W-1:0]  cur;
	logic [7:0]           k_sel;
	logic [RECIP_W-1:0]   rcp_sel;
	logic [SH_W-1:0]      sh_sel;
	logic [QUO_W-1:0]     quo;

	assign sample_ch.ready = (ctrl.op == OP_LOAD);
	assign load_xfer = sample_ch.valid && (ctrl.op == OP_LOAD);

	assign status.in_valid = sample_ch.valid;
	assign status.idx_last = (idx_q == SLOT_W'(WINDOW - 1));
	assign status.out_free = !out_valid_q || result_ch.ready;

	assign out_load = (ctrl.op == OP_OUT) && status.out_free;

	assign result_ch.valid       = out_valid_q;
	assign result_ch.reading     = reading_q;
	assign result_ch.trimmed_sum = osum_q;

	assign cur = ring_q[idx_q];

	always_comb begin
		case (mode_q)
			MODE_REF3V: begin
				k_sel   = K_REF3V;
				rcp_sel = RCP_REF3V;
				sh_sel  = SH_REF3V;
			end
			MODE_SAT3300: begin
				k_sel   = K_SAT3300;
				rcp_sel = RCP_SAT3300;
				sh_sel  = SH_SAT3300;
			end
			MODE_DIV16: begin
				k_sel   = K_DIV16;
				rcp_sel = RCP_DIV16;
				sh_sel  = SH_DIV16;
			end
			MODE_DIV4096: begin
				k_sel   = K_DIV4096;
				rcp_sel = RCP_DIV4096;
				sh_sel  = SH_DIV4096;
			end
			default: begin
				k_sel   = K_REF3V;
				rcp_sel = RCP_REF3V;
				sh_sel  = SH_REF3V;
			end
		endcase
		quo = QUO_W'(prod_q >> sh_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			slot_q      <= '0;
			mode_q      <= MODE_REF3V;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= mode_t'(cfg_wdata);
			end
			if (load_xfer) begin
				ring_q[slot_q] <= sample_ch.sample;
				if (slot_q == SLOT_W'(WINDOW - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				idx_q <= '0;
				acc_q <= '0;
				lo_q  <= SAMPLE_MAX;
				hi_q  <= '0;
			end
			OP_ACC: begin
				acc_q <= acc_q + SUM_W'(cur);
				if (cur < lo_q) begin
					lo_q <= cur;
				end
				if (cur > hi_q) begin
					hi_q <= cur;
				end
				if (!status.idx_last) begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end
			OP_TRIM: begin
				tsum_q <= acc_q - SUM_W'(lo_q) - SUM_W'(hi_q);
			end
			OP_MUL: begin
				num_q <= NUM_W'(tsum_q) * NUM_W'(k_sel);
			end
			OP_DIV: begin
				prod_q <= PROD_W'(num_q) * PROD_W'(rcp_sel);
			end
			OP_OUT: begin
				if (out_load) begin
					reading_q <= (quo[QUO_W-1:READING_W] != '0) ? {READING_W{1'b1}}
						: quo[READING_W-1:0];
					osum_q    <= TSUM_W'(tsum_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the trimmed-mean sensor scaler core.
`timescale 1ns / 1ps
module tb_top;
	import stms_pkg::*;

	localparam int STUCK_LIMIT = 5000;
	localparam int SETTLE      = WINDOW + 20;

	typedef struct {
		logic [READING_W-1:0] reading;
		logic [TSUM_W-1:0]    trimmed_sum;
	} ppb_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;

	stms_sample_if sample_ch ();
	stms_result_if result_ch ();

	sensor_trimmed_mean_scaler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// shadow of the block state
	logic [SAMPLE_W-1:0] ring_model [WINDOW];
	int unsigned         slot_model;
	mode_t               mode_model;
	ppb_result_t         pending_results [$];

	int mismatches;
	int stuck_cycles;

	// receiver control
	int rx_style;
	int rx_hold_len;
	int rx_hold_reqs;
	int rx_hold_seen;
	int rx_hold_left;
	int rx_pattern_cnt;

	initial forever #5 clk = ~clk;

	function automatic logic [READING_W-1:0] scale_to_ppb(input int unsigned s, input mode_t m);
		longint unsigned d;
		longint unsigned r;
		d = WINDOW - 2;
		case (m)
			MODE_REF3V:   r = (longint'(s) * 153) / (d * 4095);
			MODE_SAT3300: r = (longint'(s) * 255) / (d * 3300);
			MODE_DIV16:   r = longint'(s) / (d * 16);
			default:      r = (longint'(s) * 25) / (d * 1024);
		endcase
		if (r > 255)
			r = 255;
		return r[READING_W-1:0];
	endfunction

	function automatic void predict_trimmed_ppb(input logic [SAMPLE_W-1:0] s);
		int unsigned sum;
		int unsigned lo;
		int unsigned hi;
		ppb_result_t res;
		if (slot_model >= WINDOW)
			slot_model = 0;
		ring_model[slot_model] = s;
		slot_model = (slot_model + 1 >= WINDOW) ? 0 : slot_model + 1;
		sum = 0;
		lo = SAMPLE_MAX;
		hi = 0;
		for (int i = 0; i < WINDOW; i++) begin
			sum += ring_model[i];
			if (ring_model[i] < lo)
				lo = ring_model[i];
			if (ring_model[i] > hi)
				hi = ring_model[i];
		end
		sum = sum - lo - hi;
		res.reading     = scale_to_ppb(sum, mode_model);
		res.trimmed_sum = sum[TSUM_W-1:0];
		pending_results.push_back(res);
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		@(negedge clk);
		sample_ch.valid  = 1'b1;
		sample_ch.sample = s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predict_trimmed_ppb(s);
	endtask

	task automatic idle_sender(input int cycles);
		@(negedge clk);
		sample_ch.valid = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		idle_sender(1);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_scale_mode(input mode_t m);
		drain_results();
		repeat (WINDOW + 12) @(posedge clk);
		@(negedge clk);
		cfg_we     = 1'b1;
		cfg_wdata  = m;
		mode_model = m;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] draw_sample(input int flavor,
			input logic [SAMPLE_W-1:0] base);
		case (flavor)
			0:       return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			1:       return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
			2:       return base ^ SAMPLE_W'($urandom_range(0, 3));
			default: return SAMPLE_W'($urandom_range(0, 31)) << $urandom_range(0, 7);
		endcase
	endfunction

	task automatic stream_samples(input int count, input bit gappy);
		int burst_left;
		int flavor;
		logic [SAMPLE_W-1:0] base;
		burst_left = 0;
		flavor = 0;
		base = '0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				if (gappy)
					idle_sender($urandom_range(1, 12));
				burst_left = $urandom_range(1, 24);
				flavor = $urandom_range(0, 3);
				base = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
			end
			send_sample(draw_sample(flavor, base));
			burst_left--;
		end
	endtask

	task automatic test_early_windows();
		rx_style = 0;
		send_sample(SAMPLE_MAX);
		send_sample(12'd1);
		send_sample(12'd2048);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
	endtask

	task automatic test_scale_extremes();
		write_scale_mode(MODE_SAT3300);
		repeat (8) send_sample(SAMPLE_MAX);
		write_scale_mode(MODE_REF3V);
		send_sample(SAMPLE_MAX);
		write_scale_mode(MODE_DIV16);
		send_sample(SAMPLE_MAX);
		write_scale_mode(MODE_DIV4096);
		send_sample(SAMPLE_MAX);
	endtask

	task automatic test_ties_and_patterns();
		write_scale_mode(MODE_DIV16);
		rx_style = 1;
		repeat (3) send_sample('0);
		send_sample(12'hAAA);
		send_sample(12'h555);
	endtask

	task automatic test_random_traffic();
		mode_t modes [4];
		modes = '{MODE_REF3V, MODE_SAT3300, MODE_DIV16, MODE_DIV4096};
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 4)
				write_scale_mode(modes[ph]);
			else
				write_scale_mode(modes[$urandom_range(0, 3)]);
			rx_style = (ph == 2) ? 0 : $urandom_range(0, 2);
			stream_samples(150, ph != 2);
		end
	endtask

	task automatic test_backpressure_and_drain();
		write_scale_mode(MODE_SAT3300);
		rx_style = 0;
		rx_hold_len = 300;
		rx_hold_reqs++;
		stream_samples(30, 1'b0);
		drain_results();
		rx_style = 1;
		stream_samples(20, 1'b1);
	endtask

	// receiver
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_reqs != rx_hold_seen) begin
				rx_hold_seen = rx_hold_reqs;
				rx_hold_left = rx_hold_len;
			end
			if (rx_hold_left > 0) begin
				result_ch.ready = 1'b0;
				rx_hold_left--;
			end else begin
				case (rx_style)
					0: result_ch.ready = 1'b1;
					1: result_ch.ready = $urandom_range(0, 99) >= 35;
					default: result_ch.ready = (rx_pattern_cnt % 11) < 6;
				endcase
			end
			rx_pattern_cnt++;
		end
	end

	// result checker
	always @(posedge clk) begin
		ppb_result_t exp_res;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: reading %0d trimmed_sum %0d",
						result_ch.reading, result_ch.trimmed_sum);
			end else begin
				exp_res = pending_results.pop_front();
				if (result_ch.reading !== exp_res.reading) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reading mismatch: expected %0d actual %0d",
							exp_res.reading, result_ch.reading);
				end
				if (result_ch.trimmed_sum !== exp_res.trimmed_sum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("trimmed_sum mismatch: expected %0d actual %0d",
							exp_res.trimmed_sum, result_ch.trimmed_sum);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (pending_results.size() == 0 && !sample_ch.valid))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("sensor_trimmed_mean_scaler_core verification failed");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		mismatches       = 0;
		stuck_cycles     = 0;
		rx_style         = 0;
		rx_hold_len      = 0;
		rx_hold_reqs     = 0;
		rx_hold_seen     = 0;
		rx_hold_left     = 0;
		rx_pattern_cnt   = 0;
		slot_model       = 0;
		mode_model       = MODE_REF3V;
		for (int i = 0; i < WINDOW; i++)
			ring_model[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_early_windows();
		test_scale_extremes();
		test_ties_and_patterns();
		test_random_traffic();
		test_backpressure_and_drain();

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("sensor_trimmed_mean_scaler_core verification clean");
		else
			$display("sensor_trimmed_mean_scaler_core verification failed");
		$finish;
	end

endmodule
